// File: hdl/qrr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrr_pkg
// shared widths, status codes and word types of the quadratic root solver
// ----------------------------------------------------------------------------
package qrr_pkg;

   localparam int COEF_BITS = 16;
   localparam int FRAC_BITS = 16;
   localparam int DISC_W    = 34;
   localparam int VAL_W     = 40;

   // internal widths
   localparam int DW     = 2 * COEF_BITS + 2;        // exact discriminant
   localparam int MAG_W  = DW;                       // |D|
   localparam int ND     = COEF_BITS + 1 + FRAC_BITS; // root digits
   localparam int RAD_W  = 2 * ND;                   // radicand bits
   localparam int RW     = ND + 3;                   // sqrt remainder
   localparam int NB_W   = COEF_BITS + FRAC_BITS + 1; // -b scaled
   localparam int NUM_W  = COEF_BITS + 2 + FRAC_BITS; // dividend magnitude
   localparam int DEN_W  = COEF_BITS + 1;            // |2a|
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   typedef enum logic [1:0] {
      STATUS_REAL    = 2'd0,
      STATUS_COMPLEX = 2'd1,
      STATUS_DEGEN   = 2'd2
   } status_type;

   typedef struct packed {
      status_type               status;
      logic signed [DISC_W-1:0] disc;
      logic signed [NB_W-1:0]   nb;
      logic                     den_neg;
      logic [DEN_W-1:0]         den_mag;
   } job_type;

   typedef struct packed {
      job_type          job;
      logic [MAG_W-1:0] mag;
   } item_type;

endpackage
`default_nettype wire

// File: hdl/quadratic_roots_real_coeff.sv
`default_nettype none
// pipeline: 73 register stages (2 front, 1 queue, ND+1 square root, NUM_W+1
// divider, 1 output) at 16/16 bits
// throughput: one word per cycle, set by the pipelined root and divider
// stages; a full queue or a held result stalls the affected side
// reset: synchronous, active high, clears all valid bits and the queue
// ----------------------------------------------------------------------------
// quadratic_roots_real_coeff
// real or complex roots of a*x^2 + b*x + c in signed fixed point
// ----------------------------------------------------------------------------
module quadratic_roots_real_coeff import qrr_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [COEF_BITS-1:0] req_coef_a,
   input  wire logic signed [COEF_BITS-1:0] req_coef_b,
   input  wire logic signed [COEF_BITS-1:0] req_coef_c,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic signed [DISC_W-1:0]         rsp_discriminant,
   output logic signed [VAL_W-1:0]          rsp_first_value,
   output logic signed [VAL_W-1:0]          rsp_second_value
);

   logic                  push, full, empty, pop, en;
   item_type              push_item, head;
   logic                  sq_valid, dv_valid;
   job_type               sq_job, dv_job;
   logic [ND-1:0]         sq_root;
   logic signed [NUM_W:0] dv_first, dv_second;

   logic                    rsp_valid_ff;
   status_type              status_ff;
   logic signed [DISC_W-1:0] disc_ff;
   logic signed [VAL_W-1:0] first_ff, second_ff;

   // back part advances unless a result is held
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign pop       = en && !empty;
   assign req_stall = full;

   qrr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_coef_a (req_coef_a),
      .req_coef_b (req_coef_b),
      .req_coef_c (req_coef_c),
      .full       (full),
      .push       (push),
      .push_item  (push_item)
   );

   qrr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   qrr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (!empty),
      .in_item   (head),
      .out_valid (sq_valid),
      .out_job   (sq_job),
      .out_root  (sq_root)
   );

   qrr_divide u_divide (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (sq_valid),
      .in_job     (sq_job),
      .in_root    (sq_root),
      .out_valid  (dv_valid),
      .out_job    (dv_job),
      .out_first  (dv_first),
      .out_second (dv_second)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         status_ff <= dv_job.status;
         disc_ff   <= dv_job.disc;
         if (dv_job.status == STATUS_DEGEN) begin
            first_ff  <= '0;
            second_ff <= '0;
         end else begin
            first_ff  <= VAL_W'(dv_first);
            second_ff <= VAL_W'(dv_second);
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_discriminant = disc_ff;
   assign rsp_first_value  = first_ff;
   assign rsp_second_value = second_ff;

endmodule
`default_nettype wire

// File: hdl/qrr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrr_front
// registers coefficients, forms the discriminant and classifies the word
// ----------------------------------------------------------------------------
module qrr_front import qrr_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic signed [COEF_BITS-1:0] req_coef_a,
   input  wire logic signed [COEF_BITS-1:0] req_coef_b,
   input  wire logic signed [COEF_BITS-1:0] req_coef_c,
   input  wire logic                        full,
   output logic                             push,
   output item_type                         push_item
);

   logic                          v1_ff, v2_ff;
   logic signed [COEF_BITS-1:0]   a1_ff, b1_ff, c1_ff;
   logic signed [COEF_BITS-1:0]   a2_ff, b2_ff;
   logic signed [2*COEF_BITS-1:0] bb2_ff, ac2_ff;
   logic signed [DW-1:0]          d;
   logic signed [NB_W-1:0]        nb;
   logic signed [DEN_W-1:0]       den;
   logic                          en;

   assign en = !full;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
   end

   // input register and products
   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff  <= req_coef_a;
         b1_ff  <= req_coef_b;
         c1_ff  <= req_coef_c;
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         bb2_ff <= b1_ff * b1_ff;
         ac2_ff <= a1_ff * c1_ff;
      end
   end

   // discriminant and classification
   always_comb begin
      d   = DW'(bb2_ff) - (DW'(ac2_ff) <<< 2);
      nb  = -(NB_W'(b2_ff) <<< FRAC_BITS);
      den = DEN_W'(a2_ff) <<< 1;
      push = v2_ff && !full;
      push_item.job.disc    = DISC_W'(d);
      push_item.job.nb      = nb;
      push_item.job.den_neg = den[DEN_W-1];
      push_item.job.den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      push_item.mag         = d[DW-1] ? MAG_W'(-d) : MAG_W'(d);
      priority if (a2_ff == '0) begin
         push_item.job.status = STATUS_DEGEN;
      end else if (d[DW-1]) begin
         push_item.job.status = STATUS_COMPLEX;
      end else begin
         push_item.job.status = STATUS_REAL;
      end
   end

endmodule
`default_nettype wire

// File: hdl/qrr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrr_queue
// short fifo between the front and back parts
// ----------------------------------------------------------------------------
module qrr_queue import qrr_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  item_type      push_item,
   input  wire logic     pop,
   output logic          full,
   output logic          empty,
   output item_type      head
);

   item_type       mem [QDEPTH];
   logic [QAW-1:0] wr_ff, rd_ff;
   logic [QAW:0]   cnt_ff;

   assign full  = (cnt_ff == (QAW+1)'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QAW+1)'(push) - (QAW+1)'(pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_item;
   end

endmodule
`default_nettype wire

// File: hdl/qrr_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrr_sqrt
// pipelined digit-by-digit square root of |D| * 2^(2*FRAC_BITS)
// ----------------------------------------------------------------------------
module qrr_sqrt import qrr_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire logic     in_valid,
   input  item_type      in_item,
   output logic          out_valid,
   output job_type       out_job,
   output logic [ND-1:0] out_root
);

   logic             v_ff    [ND+1];
   job_type          job_ff  [ND+1];
   logic [RAD_W-1:0] rad_ff  [ND+1];
   logic [RW-1:0]    rem_ff  [ND+1];
   logic [ND-1:0]    root_ff [ND+1];

   // load stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         job_ff[0]  <= in_item.job;
         rad_ff[0]  <= RAD_W'(in_item.mag) << (2 * FRAC_BITS);
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   // one root digit per stage
   for (genvar i = 0; i < ND; i++) begin : g_stage
      logic [RW-1:0] nw, tr;
      logic          ge;

      always_comb begin
         nw = {rem_ff[i][RW-3:0], rad_ff[i][RAD_W-1 -: 2]};
         tr = {1'b0, root_ff[i], 2'b01};
         ge = (nw >= tr);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            job_ff[i+1]  <= job_ff[i];
            rad_ff[i+1]  <= rad_ff[i] << 2;
            rem_ff[i+1]  <= ge ? RW'(nw - tr) : nw;
            root_ff[i+1] <= {root_ff[i][ND-2:0], ge};
         end
      end
   end

   assign out_valid = v_ff[ND];
   assign out_job   = job_ff[ND];
   assign out_root  = root_ff[ND];

endmodule
`default_nettype wire

// File: hdl/qrr_divide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrr_divide
// two pipelined restoring dividers by 2a, truncating toward zero
// ----------------------------------------------------------------------------
module qrr_divide import qrr_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  job_type                  in_job,
   input  wire logic [ND-1:0]       in_root,
   output logic                     out_valid,
   output job_type                  out_job,
   output logic signed [NUM_W:0]    out_first,
   output logic signed [NUM_W:0]    out_second
);

   logic             v_ff   [NUM_W+1];
   job_type          job_ff [NUM_W+1];
   logic             neg_ff [2][NUM_W+1];
   logic [NUM_W-1:0] num_ff [2][NUM_W+1];
   logic [DEN_W-1:0] rem_ff [2][NUM_W+1];
   logic [NUM_W-1:0] quo_ff [2][NUM_W+1];

   logic signed [NUM_W:0] nb_x, s_x;
   logic signed [NUM_W:0] dvd [2];

   // dividends for both lanes
   always_comb begin
      nb_x = (NUM_W+1)'(in_job.nb);
      s_x  = $signed({{(NUM_W+1-ND){1'b0}}, in_root});
      if (in_job.status == STATUS_COMPLEX) begin
         dvd[0] = nb_x;
         dvd[1] = s_x;
      end else begin
         dvd[0] = nb_x + s_x;
         dvd[1] = nb_x - s_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) job_ff[0] <= in_job;
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      // load stage
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[l][0] <= dvd[l][NUM_W] ^ in_job.den_neg;
            num_ff[l][0] <= dvd[l][NUM_W] ? NUM_W'(-dvd[l]) : NUM_W'(dvd[l]);
            rem_ff[l][0] <= '0;
            quo_ff[l][0] <= '0;
         end
      end

      // one quotient bit per stage
      for (genvar i = 0; i < NUM_W; i++) begin : g_stage
         logic [DEN_W:0] r;
         logic           ge;

         always_comb begin
            r  = {rem_ff[l][i], num_ff[l][i][NUM_W-1]};
            ge = (r >= {1'b0, job_ff[i].den_mag});
         end

         always_ff @(posedge clock) begin
            if (en) begin
               neg_ff[l][i+1] <= neg_ff[l][i];
               num_ff[l][i+1] <= num_ff[l][i] << 1;
               rem_ff[l][i+1] <= ge ? DEN_W'(r - {1'b0, job_ff[i].den_mag})
                                    : DEN_W'(r);
               quo_ff[l][i+1] <= {quo_ff[l][i][NUM_W-2:0], ge};
            end
         end
      end
   end

   for (genvar i = 0; i < NUM_W; i++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) job_ff[i+1] <= job_ff[i];
      end
   end

   // sign of the quotient
   assign out_valid  = v_ff[NUM_W];
   assign out_job    = job_ff[NUM_W];
   assign out_first  = neg_ff[0][NUM_W] ? -$signed({1'b0, quo_ff[0][NUM_W]})
                                        :  $signed({1'b0, quo_ff[0][NUM_W]});
   assign out_second = neg_ff[1][NUM_W] ? -$signed({1'b0, quo_ff[1][NUM_W]})
                                        :  $signed({1'b0, quo_ff[1][NUM_W]});

endmodule
`default_nettype wire
